// File: rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of i_clk, off while i_rst_n is low
`define CSVFT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("csvft assertion failed");

// implication form, same clocking
`define CSVFT_ASSERT_IMP(lbl, pre, post) \
    `CSVFT_ASSERT(lbl, (pre) |-> (post))

`endif

// File: rtl/core/csvft_pkg.sv
// shared types, constants and helpers of the csv field classifier
package csvft_pkg;

    localparam logic [7:0]  C_NEWLINE   = 8'd10;
    localparam logic [7:0]  C_PLUS      = 8'd43;
    localparam logic [7:0]  C_MINUS     = 8'd45;
    localparam logic [7:0]  C_DOT       = 8'd46;
    localparam logic [7:0]  C_DELIM_RST = 8'd44;
    localparam logic [31:0] C_MAG_CAP   = 32'h8000_0000;
    localparam logic [31:0] C_INT_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        KIND_STR   = 2'd0,
        KIND_INT   = 2'd1,
        KIND_FLOAT = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_BODY  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_STR   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_req;

    typedef struct packed {
        t_kind              field_kind;
        logic signed [31:0] int_value;
        logic               int_overflow;
        logic [15:0]        byte_count;
        logic [7:0]         field_number;
        logic [31:0]        row_number;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

endpackage

// File: rtl/core/csv_field_type_classifier.sv
// top level of the csv field splitter and type classifier
//
//  channel  | direction | handshake                     | carries
//  ---------+-----------+-------------------------------+------------------------------
//  text     | in        | i_text_valid / o_text_ready   | one byte, end of buffer flag
//  field    | out       | o_field_valid / i_field_ready | kind, value, length, position
//  delim    | in        | i_delim_we (no wait)          | field separator byte
//
//  one byte request per cycle while the result register is free; a byte is held
//  in the input register and its field result is then loaded into the result register
//  the per-byte state update (digit accumulate with multiply by ten) sets the cycle
//  reset is synchronous, active low; delimiter returns to comma
//  a stalled field request holds the result register; bytes keep flowing as
//  long as the result register is empty or being taken this cycle
`include "assert_macros.svh"

module csv_field_type_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_delim_we,
    input  logic [7:0]         i_delim_data,
    // text byte requests
    input  logic               i_text_valid,
    output logic               o_text_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_final_byte,
    // field result requests
    output logic               o_field_valid,
    input  logic               i_field_ready,
    output logic [1:0]         o_field_kind,
    output logic signed [31:0] o_int_value,
    output logic               o_int_overflow,
    output logic [15:0]        o_byte_count,
    output logic [7:0]         o_field_number,
    output logic [31:0]        o_row_number
);

    logic               in_valid;
    csvft_pkg::t_req    in_req;
    logic               take;
    logic               emit;
    logic               out_free;
    csvft_pkg::t_result scan_result;
    csvft_pkg::t_result out_result;

    // a byte is consumed only when the result register can take whatever it emits
    assign take = in_valid && out_free;

    csvft_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_text_valid),
        .o_ready      (o_text_ready),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .i_take       (take),
        .o_valid      (in_valid),
        .o_req        (in_req)
    );

    csvft_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_delim_we   (i_delim_we),
        .i_delim_data (i_delim_data),
        .i_take       (take),
        .i_req        (in_req),
        .o_emit       (emit),
        .o_result     (scan_result)
    );

    csvft_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && emit),
        .i_result (scan_result),
        .i_ready  (i_field_ready),
        .o_valid  (o_field_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_field_kind   = out_result.field_kind;
    assign o_int_value    = out_result.int_value;
    assign o_int_overflow = out_result.int_overflow;
    assign o_byte_count   = out_result.byte_count;
    assign o_field_number = out_result.field_number;
    assign o_row_number   = out_result.row_number;

    // header line never classifies as a number
    `CSVFT_ASSERT_IMP(a_header_is_string,
        o_field_valid && (o_row_number == 32'd0),
        o_field_kind == csvft_pkg::KIND_STR)

    // saturation flag only on integer fields
    `CSVFT_ASSERT_IMP(a_ovf_only_int,
        o_field_valid && o_int_overflow,
        o_field_kind == csvft_pkg::KIND_INT)

    // non-integer fields carry a zero value
    `CSVFT_ASSERT_IMP(a_value_zero_otherwise,
        o_field_valid && (o_field_kind != csvft_pkg::KIND_INT),
        o_int_value == 32'sd0)

    // a numeric field holds at least one byte
    `CSVFT_ASSERT_IMP(a_number_nonempty,
        o_field_valid && (o_field_kind != csvft_pkg::KIND_STR),
        o_byte_count != 16'd0)

endmodule

// File: rtl/core/csvft_in_stage.sv
// input register holding one text byte request
module csvft_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_text_byte,
    input  logic            i_final_byte,
    input  logic            i_take,
    output logic            o_valid,
    output csvft_pkg::t_req o_req
);

    logic            r_valid;
    logic            n_valid;
    csvft_pkg::t_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req.text_byte  <= i_text_byte;
            r_req.final_byte <= i_final_byte;
        end
    end

endmodule

// File: rtl/core/csvft_scan.sv
// field splitter state, per byte classification and result build
module csvft_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_delim_we,
    input  logic [7:0]         i_delim_data,
    input  logic               i_take,
    input  csvft_pkg::t_req    i_req,
    output logic               o_emit,
    output csvft_pkg::t_result o_result
);

    logic [7:0]        r_delim;
    csvft_pkg::t_phase r_phase,   n_phase;
    logic              r_dot,     n_dot;
    logic              r_digit,   n_digit;
    logic              r_neg,     n_neg;
    logic [31:0]       r_mag,     n_mag;
    logic              r_sat,     n_sat;
    logic [15:0]       r_len,     n_len;
    logic [7:0]        r_field,   n_field;
    logic [31:0]       r_line,    n_line;

    // state after absorbing the byte
    csvft_pkg::t_phase a_phase;
    logic              a_dot;
    logic              a_digit;
    logic              a_neg;
    logic [31:0]       a_mag;
    logic              a_sat;
    logic [15:0]       a_len;

    // state that the emitted field is built from
    csvft_pkg::t_phase e_phase;
    logic              e_dot;
    logic              e_digit;
    logic              e_neg;
    logic [31:0]       e_mag;
    logic              e_sat;
    logic [15:0]       e_len;

    logic [7:0]  c;
    logic        is_nl;
    logic        is_delim;
    logic        is_dig;
    logic        is_blk;
    logic [35:0] mag_next;
    logic        clear;

    assign c        = i_req.text_byte;
    assign is_nl    = (c == csvft_pkg::C_NEWLINE);
    assign is_delim = !is_nl && (c == r_delim);
    assign is_dig   = csvft_pkg::is_digit(c);
    assign is_blk   = csvft_pkg::is_blank(c);
    // mag * 10 + digit, digit is the low nibble of an ascii digit
    assign mag_next = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {32'd0, c[3:0]};

    always_comb begin
        a_phase = r_phase;
        a_dot   = r_dot;
        a_digit = r_digit;
        a_neg   = r_neg;
        a_mag   = r_mag;
        a_sat   = r_sat;
        a_len   = (r_len != 16'hFFFF) ? r_len + 16'd1 : r_len;
        case (r_phase)
            csvft_pkg::PH_LEAD, csvft_pkg::PH_SIGN, csvft_pkg::PH_BODY: begin
                if (is_dig) begin
                    a_digit = 1'b1;
                    a_phase = csvft_pkg::PH_BODY;
                    if (mag_next > {4'd0, csvft_pkg::C_MAG_CAP}) begin
                        a_mag = csvft_pkg::C_MAG_CAP;
                        a_sat = 1'b1;
                    end else begin
                        a_mag = mag_next[31:0];
                    end
                end else if ((c == csvft_pkg::C_DOT) && !r_dot) begin
                    a_dot   = 1'b1;
                    a_phase = csvft_pkg::PH_BODY;
                end else if (is_blk) begin
                    if (r_phase != csvft_pkg::PH_LEAD) begin
                        a_phase = csvft_pkg::PH_TRAIL;
                    end
                end else if (((c == csvft_pkg::C_PLUS) || (c == csvft_pkg::C_MINUS))
                             && (r_phase == csvft_pkg::PH_LEAD)) begin
                    a_neg   = (c == csvft_pkg::C_MINUS);
                    a_phase = csvft_pkg::PH_SIGN;
                end else begin
                    a_phase = csvft_pkg::PH_STR;
                end
            end
            csvft_pkg::PH_TRAIL: begin
                if (!is_blk) begin
                    a_phase = csvft_pkg::PH_STR;
                end
            end
            default: begin
                a_phase = csvft_pkg::PH_STR;
            end
        endcase
    end

    // newline and delimiter emit the field as it stands, other bytes after absorbing
    always_comb begin
        if (is_nl || is_delim) begin
            e_phase = r_phase;
            e_dot   = r_dot;
            e_digit = r_digit;
            e_neg   = r_neg;
            e_mag   = r_mag;
            e_sat   = r_sat;
            e_len   = r_len;
        end else begin
            e_phase = a_phase;
            e_dot   = a_dot;
            e_digit = a_digit;
            e_neg   = a_neg;
            e_mag   = a_mag;
            e_sat   = a_sat;
            e_len   = a_len;
        end
    end

    always_comb begin
        if (is_nl) begin
            o_emit = (r_len != 16'd0);
        end else if (is_delim) begin
            o_emit = 1'b1;
        end else begin
            o_emit = i_req.final_byte;
        end
    end

    always_comb begin
        o_result.field_kind   = csvft_pkg::KIND_STR;
        o_result.int_value    = '0;
        o_result.int_overflow = 1'b0;
        o_result.byte_count   = e_len;
        o_result.field_number = r_field;
        o_result.row_number   = r_line;
        if ((e_phase != csvft_pkg::PH_STR) && e_digit && (r_line != 32'd0)) begin
            o_result.field_kind = e_dot ? csvft_pkg::KIND_FLOAT : csvft_pkg::KIND_INT;
        end
        if ((e_phase != csvft_pkg::PH_STR) && e_digit && (r_line != 32'd0) && !e_dot) begin
            if (e_neg) begin
                o_result.int_overflow = e_sat;
                o_result.int_value    = $signed(32'd0 - e_mag);
            end else if (e_mag >= csvft_pkg::C_MAG_CAP) begin
                o_result.int_overflow = 1'b1;
                o_result.int_value    = $signed(csvft_pkg::C_INT_MAX);
            end else begin
                o_result.int_value    = $signed(e_mag);
            end
        end
    end

    assign clear = is_nl || is_delim || i_req.final_byte;

    always_comb begin
        n_phase = a_phase;
        n_dot   = a_dot;
        n_digit = a_digit;
        n_neg   = a_neg;
        n_mag   = a_mag;
        n_sat   = a_sat;
        n_len   = a_len;
        n_field = r_field;
        n_line  = r_line;
        if (clear) begin
            n_phase = csvft_pkg::PH_LEAD;
            n_dot   = 1'b0;
            n_digit = 1'b0;
            n_neg   = 1'b0;
            n_mag   = '0;
            n_sat   = 1'b0;
            n_len   = '0;
        end
        if (is_nl) begin
            n_field = '0;
            if (r_line != 32'hFFFF_FFFF) begin
                n_line = r_line + 32'd1;
            end
        end else if (is_delim && (r_field != 8'hFF)) begin
            n_field = r_field + 8'd1;
        end
        // end of buffer starts over at line 0
        if (i_req.final_byte) begin
            n_field = '0;
            n_line  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= csvft_pkg::C_DELIM_RST;
        end else if (i_delim_we) begin
            r_delim <= i_delim_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= csvft_pkg::PH_LEAD;
            r_dot   <= 1'b0;
            r_digit <= 1'b0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_sat   <= 1'b0;
            r_len   <= '0;
            r_field <= '0;
            r_line  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_dot   <= n_dot;
            r_digit <= n_digit;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_sat   <= n_sat;
            r_len   <= n_len;
            r_field <= n_field;
            r_line  <= n_line;
        end
    end

endmodule

// File: rtl/core/csvft_out_stage.sv
// result register in front of the field request channel
module csvft_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  csvft_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output csvft_pkg::t_result o_result
);

    logic               r_valid;
    logic               n_valid;
    csvft_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: dv/tb_csv_field_type_classifier.sv
// self-checking testbench of the csv field splitter and type classifier
module tb_csv_field_type_classifier;

    // drain wait after the queues empty, before delimiter writes while idle
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int N_PHASES     = 9;
    // hang guard, run time limit in simulation time units
    localparam int RUN_LIMIT    = 400_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_delim_we = 1'b0;
    logic [7:0]         i_delim_data = 8'd0;
    logic               i_text_valid = 1'b0;
    logic               o_text_ready;
    logic [7:0]         i_text_byte = 8'd0;
    logic               i_final_byte = 1'b0;
    logic               o_field_valid;
    logic               i_field_ready = 1'b0;
    logic [1:0]         o_field_kind;
    logic signed [31:0] o_int_value;
    logic               o_int_overflow;
    logic [15:0]        o_byte_count;
    logic [7:0]         o_field_number;
    logic [31:0]        o_row_number;

    csv_field_type_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_delim_we     (i_delim_we),
        .i_delim_data   (i_delim_data),
        .i_text_valid   (i_text_valid),
        .o_text_ready   (o_text_ready),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .o_field_valid  (o_field_valid),
        .i_field_ready  (i_field_ready),
        .o_field_kind   (o_field_kind),
        .o_int_value    (o_int_value),
        .o_int_overflow (o_int_overflow),
        .o_byte_count   (o_byte_count),
        .o_field_number (o_field_number),
        .o_row_number   (o_row_number)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // byte requests waiting for the driver, field results waiting for the block
    csvft_pkg::t_req    text_q[$];
    csvft_pkg::t_result pending_fields[$];
    // scratch byte buffer used while composing a csv buffer
    logic [7:0] buf_q[$];

    int mismatch_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic text_taken = 1'b0;

    // ------------------------------------------------------------------
    // classifier model state, mirrors the block after reset
    // ------------------------------------------------------------------
    logic [7:0]        delim_reg = csvft_pkg::C_DELIM_RST;
    csvft_pkg::t_phase cls_ph = csvft_pkg::PH_LEAD;
    logic              dot_seen = 1'b0;
    logic              digit_seen = 1'b0;
    logic              neg_sign = 1'b0;
    logic [31:0]       mag = 32'd0;
    logic              mag_sat = 1'b0;
    logic [15:0]       fld_len = 16'd0;
    logic [7:0]        fld_idx = 8'd0;
    logic [31:0]       line_idx = 32'd0;

    csvft_pkg::t_result got_fld;

    // tab, line feed, vertical tab, form feed, carriage return and space
    function automatic logic blank_byte(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic clear_field();
        cls_ph     = csvft_pkg::PH_LEAD;
        dot_seen   = 1'b0;
        digit_seen = 1'b0;
        neg_sign   = 1'b0;
        mag        = 32'd0;
        mag_sat    = 1'b0;
        fld_len    = 16'd0;
    endtask

    // fold one field byte into the number detector
    task automatic absorb_byte(input logic [7:0] c);
        logic        is_dig;
        logic [63:0] nxt;
        is_dig = (c >= 8'd48) && (c <= 8'd57);
        if (fld_len != 16'hFFFF) fld_len = fld_len + 16'd1;
        case (cls_ph)
            csvft_pkg::PH_LEAD, csvft_pkg::PH_SIGN, csvft_pkg::PH_BODY: begin
                if (is_dig) begin
                    digit_seen = 1'b1;
                    nxt = {32'd0, mag} * 64'd10 + {56'd0, c - 8'd48};
                    // magnitude holds at 2^31 and flags the saturation
                    if (nxt > {32'd0, csvft_pkg::C_MAG_CAP}) begin
                        mag     = csvft_pkg::C_MAG_CAP;
                        mag_sat = 1'b1;
                    end else begin
                        mag = nxt[31:0];
                    end
                    cls_ph = csvft_pkg::PH_BODY;
                end else if (c == csvft_pkg::C_DOT && !dot_seen) begin
                    dot_seen = 1'b1;
                    cls_ph   = csvft_pkg::PH_BODY;
                end else if (blank_byte(c)) begin
                    if (cls_ph != csvft_pkg::PH_LEAD) cls_ph = csvft_pkg::PH_TRAIL;
                end else if ((c == csvft_pkg::C_PLUS || c == csvft_pkg::C_MINUS)
                             && cls_ph == csvft_pkg::PH_LEAD) begin
                    neg_sign = (c == csvft_pkg::C_MINUS);
                    cls_ph   = csvft_pkg::PH_SIGN;
                end else begin
                    cls_ph = csvft_pkg::PH_STR;
                end
            end
            csvft_pkg::PH_TRAIL: begin
                if (!blank_byte(c)) cls_ph = csvft_pkg::PH_STR;
            end
            default: cls_ph = csvft_pkg::PH_STR;
        endcase
    endtask

    // result of the field collected so far
    function automatic csvft_pkg::t_result field_snapshot();
        csvft_pkg::t_result r;
        r.field_kind   = csvft_pkg::KIND_STR;
        r.int_value    = 32'sd0;
        r.int_overflow = 1'b0;
        r.byte_count   = fld_len;
        r.field_number = fld_idx;
        r.row_number   = line_idx;
        // header line is always text
        if (cls_ph != csvft_pkg::PH_STR && digit_seen && line_idx != 32'd0)
            r.field_kind = dot_seen ? csvft_pkg::KIND_FLOAT : csvft_pkg::KIND_INT;
        if (r.field_kind == csvft_pkg::KIND_INT) begin
            if (neg_sign) begin
                r.int_overflow = mag_sat;
                r.int_value    = 32'd0 - mag;
            end else if (mag >= csvft_pkg::C_MAG_CAP) begin
                r.int_overflow = 1'b1;
                r.int_value    = csvft_pkg::C_INT_MAX;
            end else begin
                r.int_value = mag;
            end
        end
        return r;
    endfunction

    // one accepted byte request, queues the field result it closes
    task automatic classify_byte(input logic [7:0] c, input logic fin);
        logic               emit_now;
        csvft_pkg::t_result r;
        emit_now = 1'b0;
        r = field_snapshot();
        if (c == csvft_pkg::C_NEWLINE) begin
            // newline wins over a delimiter of the same code, empty fields vanish
            emit_now = (fld_len != 16'd0);
            clear_field();
            fld_idx = 8'd0;
            if (line_idx != 32'hFFFF_FFFF) line_idx = line_idx + 32'd1;
        end else if (c == delim_reg) begin
            // a delimiter always closes a field, even an empty one
            emit_now = 1'b1;
            clear_field();
            if (fld_idx != 8'hFF) fld_idx = fld_idx + 8'd1;
        end else begin
            absorb_byte(c);
            if (fin) begin
                emit_now = 1'b1;
                r = field_snapshot();
            end
        end
        if (emit_now) pending_fields.push_back(r);
        // end of buffer, next byte starts over at line 0
        if (fin) begin
            clear_field();
            fld_idx  = 8'd0;
            line_idx = 32'd0;
        end
    endtask

    task automatic report_diff(input string nm, input logic [31:0] e, input logic [31:0] g);
        mismatch_cnt++;
        $display("%0t: %s expected %0h actual %0h", $time, nm, e, g);
    endtask

    // ------------------------------------------------------------------
    // monitor: check field results, then track accepted byte requests
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        text_taken <= i_rst_n && i_text_valid && o_text_ready;
        if (i_rst_n) begin
            if (o_field_valid && i_field_ready) begin
                if (pending_fields.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: field result with none expected, expected none actual %0h",
                             $time, {o_field_kind, o_int_value, o_byte_count});
                end else begin
                    got_fld = pending_fields.pop_front();
                    if (o_field_kind !== got_fld.field_kind)
                        report_diff("field_kind", got_fld.field_kind, o_field_kind);
                    if (o_int_value !== got_fld.int_value)
                        report_diff("int_value", got_fld.int_value, o_int_value);
                    if (o_int_overflow !== got_fld.int_overflow)
                        report_diff("int_overflow", got_fld.int_overflow, o_int_overflow);
                    if (o_byte_count !== got_fld.byte_count)
                        report_diff("byte_count", got_fld.byte_count, o_byte_count);
                    if (o_field_number !== got_fld.field_number)
                        report_diff("field_number", got_fld.field_number, o_field_number);
                    if (o_row_number !== got_fld.row_number)
                        report_diff("row_number", got_fld.row_number, o_row_number);
                end
            end
            if (i_text_valid && o_text_ready)
                classify_byte(i_text_byte, i_final_byte);
        end
    end

    // ------------------------------------------------------------------
    // driver: byte requests from text_q, random gaps and result stalls
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_blk
        csvft_pkg::t_req nxt_req;
        if (!i_rst_n) begin
            i_text_valid  <= 1'b0;
            i_field_ready <= 1'b0;
        end else begin
            // a held request stays put until it is taken
            if (!i_text_valid || text_taken) begin
                if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_req = text_q.pop_front();
                    i_text_valid <= 1'b1;
                    i_text_byte  <= nxt_req.text_byte;
                    i_final_byte <= nxt_req.final_byte;
                end else begin
                    i_text_valid <= 1'b0;
                end
            end
            i_field_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++) buf_q.push_back(8'($urandom_range(48, 57)));
    endtask

    task automatic put_blanks(input int n);
        logic [7:0] blanks[5];
        blanks = '{8'd32, 8'd9, 8'd11, 8'd12, 8'd13};
        for (int i = 0; i < n; i++) buf_q.push_back(blanks[$urandom_range(4)]);
    endtask

    // move the composed buffer into the request queue
    task automatic flush_buf(input logic with_final);
        csvft_pkg::t_req r;
        while (buf_q.size() != 0) begin
            r.text_byte  = buf_q.pop_front();
            r.final_byte = with_final && (buf_q.size() == 0);
            text_q.push_back(r);
        end
    endtask

    // one field of random content, mostly numbers of every shape
    task automatic put_field();
        logic [7:0] rb;
        case ($urandom_range(9))
            0: ;  // empty field
            1, 2, 3: begin
                if ($urandom_range(2) == 0) put_blanks($urandom_range(1, 2));
                case ($urandom_range(3))
                    0: buf_q.push_back(csvft_pkg::C_PLUS);
                    1: buf_q.push_back(csvft_pkg::C_MINUS);
                    default: ;
                endcase
                if ($urandom_range(15) == 0) put_digits($urandom_range(10, 14));
                else put_digits($urandom_range(1, 5));
                if ($urandom_range(2) == 0) put_blanks($urandom_range(1, 2));
            end
            4: begin
                // saturation boundaries
                case ($urandom_range(6))
                    0: put_str("2147483647");
                    1: put_str("2147483648");
                    2: put_str("-2147483648");
                    3: put_str("-2147483649");
                    4: put_str("99999999999");
                    5: put_str("-0");
                    default: put_str("00000000000000000012");
                endcase
            end
            5, 6: begin
                if ($urandom_range(3) == 0) buf_q.push_back(csvft_pkg::C_MINUS);
                put_digits($urandom_range(0, 3));
                buf_q.push_back(csvft_pkg::C_DOT);
                put_digits($urandom_range(0, 3));
                if ($urandom_range(3) == 0) put_blanks(1);
            end
            7: begin
                case ($urandom_range(5))
                    0: put_str("1-2");
                    1: put_str("+-3");
                    2: put_str("1.2.3");
                    3: put_str(" 1 2");
                    4: put_str("abc");
                    default: put_str("7x");
                endcase
            end
            8: begin
                // raw bytes, keeping lines intact
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    rb = 8'($urandom_range(255));
                    buf_q.push_back(rb == csvft_pkg::C_NEWLINE ? 8'd0 : rb);
                end
            end
            default: begin
                // sign or blanks with no digit
                if ($urandom_range(1) == 0)
                    buf_q.push_back($urandom_range(1) ? csvft_pkg::C_PLUS : csvft_pkg::C_MINUS);
                put_blanks($urandom_range(0, 2));
            end
        endcase
    endtask

    // well-formed buffer: a header line and up to four data lines
    task automatic put_buffer(output int n);
        int lines;
        int flds;
        lines = $urandom_range(1, 5);
        for (int l = 0; l < lines; l++) begin
            flds = $urandom_range(1, 5);
            for (int f = 0; f < flds; f++) begin
                put_field();
                if (f != flds - 1) buf_q.push_back(delim_reg);
            end
            if (l != lines - 1 || $urandom_range(1) == 0) buf_q.push_back(csvft_pkg::C_NEWLINE);
        end
        if (buf_q.size() == 0) buf_q.push_back(csvft_pkg::C_NEWLINE);
        n = buf_q.size();
        // now and then a buffer runs on into the next one
        flush_buf($urandom_range(7) != 0);
    endtask

    task automatic put_noise(output int n);
        csvft_pkg::t_req r;
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++) begin
            r.text_byte  = 8'($urandom_range(255));
            r.final_byte = ($urandom_range(15) == 0);
            text_q.push_back(r);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (text_q.size() != 0 || i_text_valid || pending_fields.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // delimiter register write, only ever done while the block is idle
    task automatic set_delimiter(input logic [7:0] d);
        @(negedge i_clk);
        i_delim_we   <= 1'b1;
        i_delim_data <= d;
        @(negedge i_clk);
        i_delim_we <= 1'b0;
        delim_reg = d;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : seq_blk
        logic [7:0] delim_plan[N_PHASES];
        int         cnt;
        int         n;
        delim_plan = '{8'd44, 8'd59, 8'd0, 8'd255, csvft_pkg::C_NEWLINE, 8'd9, 8'd124,
                       8'($urandom_range(255)), 8'd44};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            // phase 0 runs on the reset value of the delimiter
            if (p > 0) begin
                wait_idle();
                set_delimiter(delim_plan[p]);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            if (p == 0) begin
                // header, signed int in blanks, float, raw extremes, empty field,
                // double dot, empty line, final byte closing a field
                put_str("h,\n -7");
                buf_q.push_back(8'd9);
                put_str(",1.5,");
                buf_q.push_back(8'hFF);
                buf_q.push_back(8'h00);
                put_str(",,1..\n\n+5");
                flush_buf(1'b1);
            end

            if (p == N_PHASES - 1) begin
                // field number saturation
                put_str("h\n");
                for (int i = 0; i < 300; i++) buf_q.push_back(delim_reg);
                buf_q.push_back(csvft_pkg::C_NEWLINE);
                for (int i = 0; i < 4; i++) buf_q.push_back(8'd32);
                put_str("-42\n");
                flush_buf(1'b1);
            end

            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                if ($urandom_range(4) == 0) put_noise(n);
                else put_buffer(n);
                cnt += n;
            end
        end

        wait_idle();
        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_fields.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/csvft_pkg.sv
rtl/core/csvft_in_stage.sv
rtl/core/csvft_scan.sv
rtl/core/csvft_out_stage.sv
rtl/core/csv_field_type_classifier.sv
dv/tb_csv_field_type_classifier.sv
